FILE: rtl/core/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared field widths, opcodes, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package bpq_pkg;

   // field widths of the request and response channels
   localparam int FIELD_VALUE_W = 32;
   localparam int FIELD_PRIO_W  = 8;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 5;

   // request opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_issue;
      logic scan_end;
      logic shift_wr;
      logic finish_pop;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_pop;
      logic full;
      logic empty;
      logic scan_last;
      logic shift_done;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/bpq_req_if.sv
// ----------------------------------------------------------------------------
// bpq_req_if
// Request channel: valid/ready handshake with push/pop payload.
// ----------------------------------------------------------------------------
interface bpq_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     opcode;
   logic signed [bpq_pkg::FIELD_VALUE_W-1:0] in_value;
   logic        [bpq_pkg::FIELD_PRIO_W-1:0]  in_priority;

   modport source (output valid, output opcode, output in_value, output in_priority,
                   input ready);
   modport sink   (input valid, input opcode, input in_value, input in_priority,
                   output ready);
endinterface

FILE: rtl/core/bpq_rsp_if.sv
// ----------------------------------------------------------------------------
// bpq_rsp_if
// Response channel: valid/ready handshake with status and popped entry.
// ----------------------------------------------------------------------------
interface bpq_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic        [bpq_pkg::STATUS_W-1:0]      status;
   logic signed [bpq_pkg::FIELD_VALUE_W-1:0] out_value;
   logic        [bpq_pkg::FIELD_PRIO_W-1:0]  out_priority;
   logic        [bpq_pkg::FILL_W-1:0]        fill_count;

   modport source (output valid, output status, output out_value, output out_priority,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input out_value, input out_priority,
                   input fill_count, output ready);
endinterface

FILE: rtl/core/bpq_ram.sv
// ----------------------------------------------------------------------------
// bpq_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// bpq_ctrl
// Sequencer for push, best-entry scan and gap-closing shift.
// ----------------------------------------------------------------------------
module bpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpq_pkg::stat_type stat,
   output bpq_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_SCAN_END = 3'd2;
   localparam logic [2:0] ST_SH_RD    = 3'd3;
   localparam logic [2:0] ST_SH_WR    = 3'd4;
   localparam logic [2:0] ST_RESULT   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.req_pop && !stat.empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            cmd.scan_end = 1'b1;
            state_in     = ST_SH_RD;
         end
         ST_SH_RD: begin
            // the RAM reads the current slot here every cycle
            if (stat.shift_done) begin
               cmd.finish_pop = 1'b1;
               state_in       = ST_RESULT;
            end else begin
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SH_RD;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/bpq_datapath.sv
// ----------------------------------------------------------------------------
// bpq_datapath
// Entry store in arrival order, best-entry compare, shift and output register.
// ----------------------------------------------------------------------------
module bpq_datapath #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int VALUE_WIDTH    = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_opcode,
   input  logic signed [bpq_pkg::FIELD_VALUE_W-1:0] req_value,
   input  logic        [bpq_pkg::FIELD_PRIO_W-1:0]  req_priority,
   input  bpq_pkg::cmd_type                         cmd,
   output bpq_pkg::stat_type                        stat,
   bpq_rsp_if.source                                rsp_bus
);

   // stored widths: the channel fields cap what can ever be kept
   localparam int SVW = (VALUE_WIDTH < bpq_pkg::FIELD_VALUE_W) ?
                        VALUE_WIDTH : bpq_pkg::FIELD_VALUE_W;
   localparam int SPW = (PRIORITY_WIDTH < bpq_pkg::FIELD_PRIO_W) ?
                        PRIORITY_WIDTH : bpq_pkg::FIELD_PRIO_W;
   localparam int ENT_W = SVW + SPW;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] idx_m1;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_pend_ff;
   logic [SVW-1:0]   best_val_ff, best_val_in;
   logic [SPW-1:0]   best_pri_ff, best_pri_in;

   logic [bpq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SVW-1:0]               res_val_ff, res_val_in;
   logic [SPW-1:0]               res_pri_ff, res_pri_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bpq_pkg::STATUS_W-1:0]      out_status_ff;
   logic [bpq_pkg::FIELD_VALUE_W-1:0] out_val_ff;
   logic [bpq_pkg::FIELD_PRIO_W-1:0]  out_pri_ff;
   logic [bpq_pkg::FILL_W-1:0]        out_fill_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;
   logic [SVW-1:0]   rd_val;
   logic [SPW-1:0]   rd_pri;

   bpq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_val = rd_data[SVW-1:0];
   assign rd_pri = rd_data[ENT_W-1:SVW];
   assign idx_m1 = idx_ff - CNT_W'(1);

   assign stat.req_pop    = (req_opcode == bpq_pkg::OP_POP);
   assign stat.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.scan_last  = (idx_ff == count_ff - CNT_W'(1));
   assign stat.shift_done = (idx_ff == count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      // running best: strict greater keeps the earliest among equal priorities
      best_in     = best_ff;
      best_val_in = best_val_ff;
      best_pri_in = best_pri_ff;
      if (rd_pend_ff && ((rd_idx_ff == '0) || (rd_pri > best_pri_ff))) begin
         best_in     = rd_idx_ff;
         best_val_in = rd_val;
         best_pri_in = rd_pri;
      end

      idx_in        = idx_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = {req_priority[SPW-1:0], req_value[SVW-1:0]};
      res_status_in = res_status_ff;
      res_val_in    = res_val_ff;
      res_pri_in    = res_pri_ff;

      if (cmd.accept) begin
         idx_in     = '0;
         res_val_in = '0;
         res_pri_in = '0;
         if (stat.req_pop) begin
            res_status_in = bpq_pkg::STATUS_EMPTY;
         end else if (stat.full) begin
            res_status_in = bpq_pkg::STATUS_FULL;
         end else begin
            res_status_in = bpq_pkg::STATUS_OK;
            wr_en         = 1'b1;
            count_in      = count_ff + CNT_W'(1);
         end
      end
      if (cmd.scan_issue || cmd.shift_wr) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.scan_end) begin
         idx_in = CNT_W'(best_in) + CNT_W'(1);
      end
      if (cmd.shift_wr) begin
         // close the gap: entry idx moves down one slot
         wr_en   = 1'b1;
         wr_addr = idx_m1[IDX_W-1:0];
         wr_data = rd_data;
      end
      if (cmd.finish_pop) begin
         count_in      = count_ff - CNT_W'(1);
         res_status_in = bpq_pkg::STATUS_OK;
         res_val_in    = best_val_ff;
         res_pri_in    = best_pri_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_pend_ff   <= cmd.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rd_idx_ff     <= idx_ff[IDX_W-1:0];
      best_ff       <= best_in;
      best_val_ff   <= best_val_in;
      best_pri_ff   <= best_pri_in;
      res_status_ff <= res_status_in;
      res_val_ff    <= res_val_in;
      res_pri_ff    <= res_pri_in;
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_val_ff    <= bpq_pkg::FIELD_VALUE_W'(res_val_ff);
         out_pri_ff    <= bpq_pkg::FIELD_PRIO_W'(res_pri_ff);
         out_fill_ff   <= bpq_pkg::FILL_W'(count_ff);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.out_value    = out_val_ff;
   assign rsp_bus.out_priority = out_pri_ff;
   assign rsp_bus.fill_count   = out_fill_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> (idx_ff < count_ff))
      else $error("scan read beyond held entries");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_pop |-> (count_ff != '0) && !rd_pend_ff)
      else $error("pop completed on empty store or with scan in flight");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result overwrote an untaken response");
`endif

endmodule

FILE: rtl/core/bounded_priority_queue_fifo_tiebreak.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue_fifo_tiebreak
// A push, or a pop on an empty queue, goes from acceptance to the result state
// and then into the response register; a pop over held entries first scans them
// through the one read port of the entry RAM, then shifts the later ones down.
// One request at a time; the next is taken once the result is staged.
// Reset clears the entry count, sequencer and response valid; the RAM keeps data.
// ----------------------------------------------------------------------------
module bounded_priority_queue_fifo_tiebreak #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int VALUE_WIDTH    = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   bpq_req_if.sink    req_bus,
   bpq_rsp_if.source  rsp_bus
);

   // Entries live in a RAM in arrival order, oldest at slot 0. A pop scans the
   // held slots once to find the highest priority (the first one wins a tie),
   // then moves every later entry down one slot to close the gap.
   bpq_pkg::cmd_type  cmd;
   bpq_pkg::stat_type stat;
   logic              req_ready;

   // hold the request channel while a request is in flight
   assign req_bus.ready = req_ready;

   bpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // the response register lets a finished result wait while the next request
   // is already being accepted
   bpq_datapath #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_opcode   (req_bus.opcode),
      .req_value    (req_bus.in_value),
      .req_priority (req_bus.in_priority),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_bus      (rsp_bus)
   );

endmodule

FILE: sim/bounded_priority_queue_fifo_tiebreak_tb.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue_fifo_tiebreak_tb
// Drives push and pop requests into the bounded priority queue through the
// request channel and checks every response against a behavioral queue model
// kept in the bench. A short scripted sequence covers empty pop, full push,
// value and priority extremes and the first-in-first-out tie-break. A long
// run of random phases, biased toward filling or draining, follows. Both
// channels stall at random, and the response side holds off once for a long
// stretch so that the queue backs up into the request channel.
// ----------------------------------------------------------------------------
module bounded_priority_queue_fifo_tiebreak_tb;

   localparam int DEPTH           = 16;
   localparam int RANDOM_ITEMS    = 1330;
   localparam int STALL_LIMIT     = 2000;  // cycles with no handshake on either side
   localparam int HOLD_OFF_CYCLES = 400;   // long response back-pressure stretch
   localparam int DRAIN_CYCLES    = 60;    // longest pop over a full queue, with margin
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [bpq_pkg::STATUS_W-1:0]             status;
      logic signed [bpq_pkg::FIELD_VALUE_W-1:0] value;
      logic [bpq_pkg::FIELD_PRIO_W-1:0]         prio;
      logic [bpq_pkg::FILL_W-1:0]               fill;
   } rsp_type;

   // one line of the scripted sequence; reps > 1 repeats a push with value + k, priority + k % 2
   typedef struct {
      logic                              op;
      logic [bpq_pkg::FIELD_VALUE_W-1:0] value;
      logic [bpq_pkg::FIELD_PRIO_W-1:0]  prio;
      int                                reps;
      bit                                typed;
      rsp_type                           want;
   } step_type;

   logic clock;
   logic reset;

   bpq_req_if req_if ();
   bpq_rsp_if rsp_if ();

   bounded_priority_queue_fifo_tiebreak u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // bench copy of the queue contents, index 0 oldest
   logic [bpq_pkg::FIELD_VALUE_W-1:0] held_value [DEPTH];
   logic [bpq_pkg::FIELD_PRIO_W-1:0]  held_prio  [DEPTH];
   int                                held_count;

   rsp_type owed_rsp [$];    // responses due, oldest first
   int      fault_count;
   bit      quiet;           // suppress random stalls on both sides
   bit      hold_off_req;    // ask the response side for its long hold-off
   int      idle_cycles;

   // -------------------------------------------------------------------------
   // clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // queue model: apply one accepted request, return the response it owes
   // -------------------------------------------------------------------------
   function automatic rsp_type queue_apply(input logic op,
                                           input logic [bpq_pkg::FIELD_VALUE_W-1:0] v,
                                           input logic [bpq_pkg::FIELD_PRIO_W-1:0] p);
      rsp_type r;
      int      best;
      int      i;
      r = '0;
      if (op == bpq_pkg::OP_PUSH) begin
         // drop the push when every slot is taken
         if (held_count >= DEPTH) begin
            r.status = bpq_pkg::STATUS_FULL;
         end else begin
            held_value[held_count] = v;
            held_prio[held_count]  = p;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = bpq_pkg::STATUS_EMPTY;
      end else begin
         // strict compare keeps the oldest entry among equal priorities
         best = 0;
         for (i = 1; i < held_count; i++) begin
            if (held_prio[i] > held_prio[best]) best = i;
         end
         r.value = held_value[best];
         r.prio  = held_prio[best];
         // close the gap so arrival order is kept
         for (i = best; i + 1 < held_count; i++) begin
            held_value[i] = held_value[i + 1];
            held_prio[i]  = held_prio[i + 1];
         end
         held_count--;
      end
      r.fill = held_count[bpq_pkg::FILL_W-1:0];
      return r;
   endfunction

   function automatic rsp_type rsp_of(input logic [bpq_pkg::STATUS_W-1:0] s,
                                      input logic [31:0] v, input logic [7:0] p,
                                      input logic [bpq_pkg::FILL_W-1:0] f);
      rsp_type r;
      r.status = s;
      r.value  = v;
      r.prio   = p;
      r.fill   = f;
      return r;
   endfunction

   function automatic step_type step(input logic op, input logic [31:0] v,
                                     input logic [7:0] p, input int reps,
                                     input bit typed, input rsp_type want);
      step_type s;
      s.op    = op;
      s.value = v;
      s.prio  = p;
      s.reps  = reps;
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   // -------------------------------------------------------------------------
   // request driver: called at a falling edge, returns at a falling edge
   // -------------------------------------------------------------------------
   task automatic put_request(input logic op, input logic [bpq_pkg::FIELD_VALUE_W-1:0] v,
                              input logic [bpq_pkg::FIELD_PRIO_W-1:0] p, input bit typed,
                              input rsp_type want);
      rsp_type predicted;
      req_if.valid       <= 1'b1;
      req_if.opcode      <= op;
      req_if.in_value    <= v;
      req_if.in_priority <= p;
      // hold the request until the queue takes it
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // advance the model on the accepting edge; typed rows still update state
      predicted = queue_apply(op, v, p);
      owed_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
      // drop valid now and then, never inside a quiet stretch
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      step_type                          script [$];
      int                                k;
      int                                sent;
      int                                phase_len;
      int                                push_pct;
      int                                prio_mode;
      logic                              op;
      logic [bpq_pkg::FIELD_VALUE_W-1:0] v;
      logic [bpq_pkg::FIELD_PRIO_W-1:0]  p;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = bpq_pkg::OP_PUSH;
      req_if.in_value    = '0;
      req_if.in_priority = '0;
      held_count         = 0;
      fault_count        = 0;
      quiet              = 1'b0;
      hold_off_req       = 1'b0;

      // pop on an empty queue after reset
      script.push_back(step(bpq_pkg::OP_POP, 32'h1234_5678, 8'hAA, 1, 1'b1,
                            rsp_of(bpq_pkg::STATUS_EMPTY, 32'h0, 8'h0, 5'd0)));
      // largest value at the top priority, then take it straight back
      script.push_back(step(bpq_pkg::OP_PUSH, 32'h7FFF_FFFF, 8'hFF, 1, 1'b1,
                            rsp_of(bpq_pkg::STATUS_OK, 32'h0, 8'h0, 5'd1)));
      script.push_back(step(bpq_pkg::OP_POP, 32'hFFFF_FFFF, 8'h00, 1, 1'b1,
                            rsp_of(bpq_pkg::STATUS_OK, 32'h7FFF_FFFF, 8'hFF, 5'd0)));
      // most negative and minus one at the lowest priority, arriving in order
      script.push_back(step(bpq_pkg::OP_PUSH, 32'h8000_0000, 8'h00, 1, 1'b1,
                            rsp_of(bpq_pkg::STATUS_OK, 32'h0, 8'h0, 5'd1)));
      script.push_back(step(bpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'h00, 1, 1'b0, '0));
      // two equal high priorities: the earlier one must come out first
      script.push_back(step(bpq_pkg::OP_PUSH, 32'd5, 8'd200, 1, 1'b0, '0));
      script.push_back(step(bpq_pkg::OP_PUSH, 32'd6, 8'd200, 1, 1'b0, '0));
      // top the queue up to its depth
      script.push_back(step(bpq_pkg::OP_PUSH, 32'd100, 8'd1, DEPTH - 4, 1'b0, '0));
      // push into a full queue is dropped
      script.push_back(step(bpq_pkg::OP_PUSH, 32'hDEAD_BEEF, 8'hFF, 1, 1'b1,
                            rsp_of(bpq_pkg::STATUS_FULL, 32'h0, 8'h0, 5'(DEPTH))));
      script.push_back(step(bpq_pkg::OP_POP, 32'h0, 8'h0, 1, 1'b0, '0));
      script.push_back(step(bpq_pkg::OP_POP, 32'h0, 8'h0, 1, 1'b0, '0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (k = 0; k < script[i].reps; k++) begin
            put_request(script[i].op, script[i].value + k,
                        8'(script[i].prio + (k % 2)),
                        script[i].typed, script[i].want);
         end
      end

      // random phases: fill-heavy, balanced or drain-heavy, with random content
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
         endcase
         prio_mode = $urandom_range(0, 2);
         for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < push_pct) ? bpq_pkg::OP_PUSH : bpq_pkg::OP_POP;
            case ($urandom_range(0, 9))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0;
               default: v = $urandom;
            endcase
            // narrow priorities force many ties, wide ones exercise the ordering
            case (prio_mode)
               0: p = 8'($urandom_range(0, 3));
               1: p = 8'($urandom_range(0, 255));
               default: p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom_range(0, 255));
            endcase
            if (sent == 250) hold_off_req = 1'b1;
            quiet = (sent >= 600 && sent < 800);
            put_request(op, v, p, 1'b0, '0);
            sent++;
         end
      end
      quiet = 1'b0;
      req_if.valid <= 1'b0;

      // drain: the watchdog bounds this wait
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("** bounded_priority_queue_fifo_tiebreak: PASSED **");
      end else begin
         $display("** bounded_priority_queue_fifo_tiebreak: FAILED **");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // response side back-pressure, including the one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            // count the hold-off here while the sender keeps offering requests
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (quiet) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // -------------------------------------------------------------------------
   // response checker: compare against the oldest owed response
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (owed_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("[%0t] unexpected response status=%0d value=%0d prio=%0d fill=%0d",
                        $time, rsp_if.status, rsp_if.out_value, rsp_if.out_priority,
                        rsp_if.fill_count);
            end
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_if.status !== want.status || rsp_if.out_value !== want.value ||
                rsp_if.out_priority !== want.prio || rsp_if.fill_count !== want.fill) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("[%0t] mismatch exp status=%0d value=%0d prio=%0d fill=%0d",
                           $time, want.status, want.value, want.prio, want.fill);
                  $display("[%0t]          got status=%0d value=%0d prio=%0d fill=%0d",
                           $time, rsp_if.status, rsp_if.out_value, rsp_if.out_priority,
                           rsp_if.fill_count);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: end the run when neither channel moves for too long; a response
   // counts as progress only while one is owed
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready && owed_rsp.size() != 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("** bounded_priority_queue_fifo_tiebreak: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: bounded_priority_queue_fifo_tiebreak.f
rtl/core/bpq_pkg.sv
rtl/core/bpq_req_if.sv
rtl/core/bpq_rsp_if.sv
rtl/core/bpq_ram.sv
rtl/core/bpq_ctrl.sv
rtl/core/bpq_datapath.sv
rtl/core/bounded_priority_queue_fifo_tiebreak.sv
sim/bounded_priority_queue_fifo_tiebreak_tb.sv
